// ----- rtl/tbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

    // Count limit of the model and the limit that fits the 16-bit result field
    localparam logic [31:0] MAX_COUNT = 32'd65535;
    localparam logic [15:0] CNT_LIMIT = (MAX_COUNT < 32'd65535) ? MAX_COUNT[15:0] : 16'hFFFF;

    // Parse phases
    typedef enum logic [2:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_WORD,
        PH_ONOFF,
        PH_DONE
    } t_phase;

    // Error codes as they appear on the result
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_EMPTY    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_INVALID  = 2'd3;

    // Keyword identifiers
    localparam logic [2:0] KW_YES   = 3'd0;
    localparam logic [2:0] KW_NO    = 3'd1;
    localparam logic [2:0] KW_TRUE  = 3'd2;
    localparam logic [2:0] KW_FALSE = 3'd3;
    localparam logic [2:0] KW_ON    = 3'd4;
    localparam logic [2:0] KW_OFF   = 3'd5;

    // Character codes
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_Y  = 8'h79;

    // One input item as held in the input register
    typedef struct packed {
        logic [7:0] code;
        logic       present;
        logic       last;
    } t_char;

    // One result item
    typedef struct packed {
        logic        bool_value;
        logic [1:0]  error_code;
        logic [15:0] consumed_count;
    } t_result;

    // Letter of a keyword at a position; zero past its end
    function automatic logic [7:0] word_char(input logic [2:0] id, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (id)
            KW_YES: begin
                case (pos)
                    3'd0: ch = "y";
                    3'd1: ch = "e";
                    3'd2: ch = "s";
                    default: ch = 8'h00;
                endcase
            end
            KW_NO: begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "o";
                    default: ch = 8'h00;
                endcase
            end
            KW_TRUE: begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_ON: begin
                case (pos)
                    3'd0: ch = "o";
                    3'd1: ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            KW_OFF: begin
                case (pos)
                    3'd0: ch = "o";
                    3'd1: ch = "f";
                    3'd2: ch = "f";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Length of a keyword; unknown identifiers behave as "yes"
    function automatic logic [2:0] word_len(input logic [2:0] id);
        logic [2:0] len;
        case (id)
            KW_YES:   len = 3'd3;
            KW_NO:    len = 3'd2;
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            KW_ON:    len = 3'd2;
            KW_OFF:   len = 3'd3;
            default:  len = 3'd3;
        endcase
        return len;
    endfunction

    // Boolean value that a keyword stands for
    function automatic logic word_val(input logic [2:0] id);
        logic val;
        case (id)
            KW_NO, KW_FALSE, KW_OFF: val = 1'b0;
            default:                 val = 1'b1;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tbp_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbp_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_char_present,
    input  wire logic          i_is_last,
    input  wire logic          i_advance,
    output logic               o_held_valid,
    output tbp_pkg::t_char     o_held
);
    import tbp_pkg::*;

    logic  r_valid;
    t_char r_char;

    // The register refuses a new transfer only while it holds an item that cannot move on
    assign o_in_stall   = r_valid && !i_advance;
    assign o_held_valid = r_valid;
    assign o_held       = r_char;

    // Valid flag of the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload of the input register
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_char.code    <= i_char_code;
            r_char.present <= i_char_present;
            r_char.last    <= i_is_last;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tbp_parse_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbp_parse_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire tbp_pkg::t_char i_char,
    output tbp_pkg::t_result    o_result
);
    import tbp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_kid, n_kid;
    logic [2:0]  r_kpos, n_kpos;
    logic [15:0] r_count, n_count;
    logic        r_value, n_value;
    logic [1:0]  r_error, n_error;

    logic [7:0]  lc;
    logic [2:0]  add;
    logic [16:0] sum;
    logic        is_space;
    logic        fin_value;
    logic [1:0]  fin_error;

    // Per-character update of the parser state
    always_comb begin
        n_phase  = r_phase;
        n_kid    = r_kid;
        n_kpos   = r_kpos;
        n_value  = r_value;
        n_error  = r_error;
        add      = 3'd0;
        lc       = i_char.code | CASE_BIT;
        is_space = (i_char.code == CH_SPACE) ||
                   (i_char.code >= CH_TAB && i_char.code <= CH_CR);
        if (i_char.present) begin
            case (r_phase)
                PH_SKIP: begin
                    if (is_space) begin
                        add = 3'd1;
                    end else if (i_char.code == CH_ZERO || i_char.code == CH_ONE) begin
                        add     = 3'd1;
                        n_value = (i_char.code == CH_ONE);
                        n_phase = PH_DIGITS;
                    end else if (lc == CH_LO_O) begin
                        n_kid   = KW_ON;
                        n_kpos  = 3'd1;
                        n_phase = PH_ONOFF;
                    end else if (lc == CH_LO_Y || lc == CH_LO_N ||
                                 lc == CH_LO_T || lc == CH_LO_F) begin
                        n_kid   = (lc == CH_LO_Y) ? KW_YES :
                                  (lc == CH_LO_N) ? KW_NO :
                                  (lc == CH_LO_T) ? KW_TRUE : KW_FALSE;
                        n_kpos  = 3'd1;
                        add     = 3'd1;
                        n_phase = PH_WORD;
                    end else begin
                        n_value = 1'b0;
                        n_error = ERR_INVALID;
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (i_char.code >= CH_ZERO && i_char.code <= CH_NINE) begin
                        if (r_value || (i_char.code != CH_ZERO && i_char.code != CH_ONE)) begin
                            n_value = 1'b0;
                            n_error = ERR_OVERFLOW;
                            n_phase = PH_DONE;
                        end else begin
                            n_value = (i_char.code == CH_ONE);
                            add     = 3'd1;
                        end
                    end else begin
                        n_error = ERR_OK;
                        n_phase = PH_DONE;
                    end
                end
                PH_WORD: begin
                    // A full word counts all its letters; a partial one only the first
                    if (r_kpos < word_len(r_kid) && lc == word_char(r_kid, r_kpos)) begin
                        n_kpos = r_kpos + 3'd1;
                        if (n_kpos >= word_len(r_kid)) begin
                            add     = word_len(r_kid) - 3'd1;
                            n_value = word_val(r_kid);
                            n_error = ERR_OK;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_value = word_val(r_kid);
                        n_error = ERR_OK;
                        n_phase = PH_DONE;
                    end
                end
                PH_ONOFF: begin
                    if (r_kid == KW_ON && lc == CH_LO_N) begin
                        add     = 3'd2;
                        n_value = 1'b1;
                        n_error = ERR_OK;
                        n_phase = PH_DONE;
                    end else if (r_kid == KW_ON && lc == CH_LO_F) begin
                        n_kid  = KW_OFF;
                        n_kpos = 3'd2;
                    end else if (r_kid == KW_OFF && lc == CH_LO_F) begin
                        add     = 3'd3;
                        n_value = 1'b0;
                        n_error = ERR_OK;
                        n_phase = PH_DONE;
                    end else begin
                        n_value = 1'b0;
                        n_error = ERR_INVALID;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Saturating character count
    assign sum     = {1'b0, r_count} + {14'd0, add};
    assign n_count = (sum >= {1'b0, CNT_LIMIT}) ? CNT_LIMIT : sum[15:0];

    // Closing of the string on its last item
    always_comb begin
        case (n_phase)
            PH_SKIP: begin
                fin_value = 1'b0;
                fin_error = ERR_EMPTY;
            end
            PH_DIGITS: begin
                fin_value = n_value;
                fin_error = ERR_OK;
            end
            PH_WORD: begin
                fin_value = word_val(n_kid);
                fin_error = ERR_OK;
            end
            PH_ONOFF: begin
                fin_value = 1'b0;
                fin_error = ERR_INVALID;
            end
            default: begin
                fin_value = n_value;
                fin_error = n_error;
            end
        endcase
        o_result.bool_value     = (fin_error == ERR_OK) ? fin_value : 1'b0;
        o_result.error_code     = fin_error;
        o_result.consumed_count = (fin_error == ERR_OK) ? n_count : 16'd0;
    end

    // State registers; a finished string returns the parser to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_kid   <= 3'd0;
            r_kpos  <= 3'd0;
            r_count <= 16'd0;
            r_value <= 1'b0;
            r_error <= ERR_OK;
        end else if (i_take) begin
            if (i_char.last) begin
                r_phase <= PH_SKIP;
                r_kid   <= 3'd0;
                r_kpos  <= 3'd0;
                r_count <= 16'd0;
                r_value <= 1'b0;
                r_error <= ERR_OK;
            end else begin
                r_phase <= n_phase;
                r_kid   <= n_kid;
                r_kpos  <= n_kpos;
                r_count <= n_count;
                r_value <= n_value;
                r_error <= n_error;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/text_to_bool_parser.sv -----
// Result: the last item of a string is registered in the input register, then its result
// in the result register. Throughput: one item per cycle while the output is not stalled;
// the parser state and the result register update in the cycle in which the item leaves
// the input register, and the two registers move together. Reset: synchronous, active low;
// clears both valid flags; the parser returns to the whitespace-skipping phase, count zero.
`timescale 1ns / 1ps
`default_nettype none

module text_to_bool_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_char_present,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_bool_value,
    output logic [1:0]       o_error_code,
    output logic [15:0]      o_consumed_count
);
    import tbp_pkg::*;

    logic    advance;
    logic    held_valid;
    t_char   held;
    t_result result;
    logic    r_out_valid;
    t_result r_out;

    // The pipeline moves whenever the result register is empty or being taken
    assign advance = !r_out_valid || !i_out_stall;

    tbp_in_stage u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_is_last      (i_is_last),
        .i_advance      (advance),
        .o_held_valid   (held_valid),
        .o_held         (held)
    );

    tbp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (held_valid && advance),
        .i_char   (held),
        .o_result (result)
    );

    // Result register valid flag: set by the last item of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= held_valid && held.last;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bool_value     = r_out.bool_value;
    assign o_error_code     = r_out.error_code;
    assign o_consumed_count = r_out.consumed_count;

endmodule

`default_nettype wire

// ----- rtl/tbp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_in_stall,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        o_bool_value,
    input  wire logic [1:0]  o_error_code,
    input  wire logic [15:0] o_consumed_count
);
    import tbp_pkg::*;

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bool_value) &&
        $stable(o_error_code) && $stable(o_consumed_count))
        else $error("stalled result changed");

    // A failed parse reports false and nothing consumed
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != ERR_OK |-> !o_bool_value && o_consumed_count == 16'd0)
        else $error("error result carries value or count");

    // A successful parse always consumed at least one character
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code == ERR_OK |-> o_consumed_count != 16'd0)
        else $error("successful result with zero count");

    // The input is held off only while a result waits on a stalled output
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind text_to_bool_parser tbp_checker u_tbp_checker (.*);

`default_nettype wire

// ----- verif/text_to_bool_parser_tb.sv -----
`timescale 1ns / 1ps

module text_to_bool_parser_tb;

    import tbp_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 9;
    localparam int MAX_GAP          = 5;
    localparam int RANDOM_ITEMS     = 1350;
    localparam int LONG_HOLD_AT     = 50;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT   = 2000;

    // One pending input transfer, with the sender's pacing hints.
    typedef struct packed {
        logic [7:0] code;
        logic       present;
        logic       last;
        logic       no_gap;
        logic       sync;
    } t_feed_char;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_code   = 8'h00;
    logic        in_present = 1'b0;
    logic        in_last   = 1'b0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_bool_value;
    logic [1:0]  o_error_code;
    logic [15:0] o_consumed_count;

    t_feed_char  char_feed[$];
    t_result     parsed_results[$];
    int          fail_count  = 0;
    int          stim_items  = 0;
    int          chars_sent  = 0;
    int          results_seen = 0;
    int          send_gap    = 0;
    int          hold_left   = 0;
    int          idle_cycles = 0;
    logic        send_quiet  = 1'b0;
    logic        recv_quiet  = 1'b0;
    logic        in_taken;
    t_feed_char  next_char;
    t_result     want;

    // Shadow copy of the parser state.
    t_phase      ph_q;
    logic [2:0]  kw_id_q;
    logic [2:0]  kw_pos_q;
    int unsigned cnt_q;
    logic        val_q;
    logic [1:0]  err_q;

    text_to_bool_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_code      (in_code),
        .i_char_present   (in_present),
        .i_is_last        (in_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_bool_value     (o_bool_value),
        .o_error_code     (o_error_code),
        .o_consumed_count (o_consumed_count)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Spelling of each keyword; an unknown identifier reads as "yes".
    function automatic string kw_word(input logic [2:0] id);
        case (id)
            KW_NO:    return "no";
            KW_TRUE:  return "true";
            KW_FALSE: return "false";
            KW_ON:    return "on";
            KW_OFF:   return "off";
            default:  return "yes";
        endcase
    endfunction

    function automatic logic kw_truth(input logic [2:0] id);
        return !(id == KW_NO || id == KW_FALSE || id == KW_OFF);
    endfunction

    task automatic reset_parser();
        ph_q     = PH_SKIP;
        kw_id_q  = KW_YES;
        kw_pos_q = 3'd0;
        cnt_q    = 0;
        val_q    = 1'b0;
        err_q    = ERR_OK;
    endtask

    // The count sticks at its limit once reached.
    task automatic count_add(input int unsigned n);
        if (cnt_q >= MAX_COUNT || n >= MAX_COUNT - cnt_q)
            cnt_q = MAX_COUNT;
        else
            cnt_q = cnt_q + n;
    endtask

    task automatic conclude(input logic val, input logic [1:0] err);
        val_q = (err != ERR_OK) ? 1'b0 : val;
        err_q = err;
        ph_q  = PH_DONE;
    endtask

    // Advances the shadow parser by one transfer and queues the result of a finished string.
    task automatic parse_char(input logic [7:0] c, input logic present, input logic last);
        logic [7:0] lc;
        string      w;
        t_result    res;
        lc = c | CASE_BIT;
        w  = kw_word(kw_id_q);
        if (present) begin
            case (ph_q)
                PH_SKIP: begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                        count_add(1);
                    end else if (c == CH_ZERO || c == CH_ONE) begin
                        count_add(1);
                        val_q = (c == CH_ONE);
                        ph_q  = PH_DIGITS;
                    end else if (lc == CH_LO_O) begin
                        kw_id_q  = KW_ON;
                        kw_pos_q = 3'd1;
                        ph_q     = PH_ONOFF;
                    end else if (lc == CH_LO_Y || lc == CH_LO_N || lc == CH_LO_T ||
                                 lc == CH_LO_F) begin
                        kw_id_q  = (lc == CH_LO_Y) ? KW_YES : (lc == CH_LO_N) ? KW_NO :
                                   (lc == CH_LO_T) ? KW_TRUE : KW_FALSE;
                        kw_pos_q = 3'd1;
                        count_add(1);
                        ph_q     = PH_WORD;
                    end else begin
                        conclude(1'b0, ERR_INVALID);
                    end
                end
                PH_DIGITS: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        if (val_q || (c != CH_ZERO && c != CH_ONE)) begin
                            conclude(1'b0, ERR_OVERFLOW);
                        end else begin
                            val_q = (c == CH_ONE);
                            count_add(1);
                        end
                    end else begin
                        conclude(val_q, ERR_OK);
                    end
                end
                PH_WORD: begin
                    if (kw_pos_q < w.len() && lc == w[kw_pos_q]) begin
                        kw_pos_q = kw_pos_q + 3'd1;
                        if (kw_pos_q >= w.len()) begin
                            count_add(w.len() - 1);
                            conclude(kw_truth(kw_id_q), ERR_OK);
                        end
                    end else begin
                        conclude(kw_truth(kw_id_q), ERR_OK);
                    end
                end
                PH_ONOFF: begin
                    if (kw_id_q == KW_ON && lc == CH_LO_N) begin
                        count_add(2);
                        conclude(1'b1, ERR_OK);
                    end else if (kw_id_q == KW_ON && lc == CH_LO_F) begin
                        kw_id_q  = KW_OFF;
                        kw_pos_q = 3'd2;
                    end else if (kw_id_q == KW_OFF && lc == CH_LO_F) begin
                        count_add(3);
                        conclude(1'b0, ERR_OK);
                    end else begin
                        conclude(1'b0, ERR_INVALID);
                    end
                end
                default: begin
                end
            endcase
        end
        if (last) begin
            case (ph_q)
                PH_SKIP:   conclude(1'b0, ERR_EMPTY);
                PH_DIGITS: conclude(val_q, ERR_OK);
                PH_WORD:   conclude(kw_truth(kw_id_q), ERR_OK);
                PH_ONOFF:  conclude(1'b0, ERR_INVALID);
                default: begin
                end
            endcase
            res.bool_value     = val_q;
            res.error_code     = err_q;
            res.consumed_count = (err_q != ERR_OK) ? 16'd0 :
                                 (cnt_q > CNT_LIMIT) ? CNT_LIMIT : cnt_q[15:0];
            parsed_results.push_back(res);
            reset_parser();
        end
    endtask

    task automatic push_char(input logic [7:0] code, input logic present, input logic last,
                             input logic no_gap = 1'b0, input logic sync = 1'b0);
        t_feed_char fc;
        fc.code    = code;
        fc.present = present;
        fc.last    = last;
        fc.no_gap  = no_gap;
        fc.sync    = sync;
        char_feed.push_back(fc);
        stim_items++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], 1'b1, i == s.len() - 1);
    endtask

    function automatic logic [7:0] random_space();
        return ($urandom_range(0, 5) == 5) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    // Mostly well-formed strings with random spacing, case and truncation; some noise.
    task automatic add_random_string();
        logic [7:0] body[$];
        logic [7:0] ch;
        string      w;
        int         kind;
        int         n;
        logic       absent_end;
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                body.push_back(random_space());
        end
        if (kind <= 4) begin
            w = kw_word(3'($urandom_range(0, 5)));
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w.len()) : w.len();
            for (int i = 0; i < n; i++) begin
                ch = w[i];
                if ($urandom_range(0, 1) == 1)
                    ch = ch & ~CASE_BIT;
                if ($urandom_range(0, 7) == 0)
                    ch = 8'($urandom_range(0, 255));
                body.push_back(ch);
            end
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                body.push_back(8'($urandom_range(0, 255)));
        end else if (kind <= 7) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0)
                    ch = CH_ZERO + 8'($urandom_range(0, 9));
                else if (i == n - 1 && $urandom_range(0, 1) == 1)
                    ch = CH_ONE;
                else
                    ch = CH_ZERO;
                body.push_back(ch);
            end
            if ($urandom_range(0, 2) == 0)
                body.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 8) begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                body.push_back(random_space());
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                body.push_back(8'($urandom_range(0, 255)));
        end
        absent_end = (body.size() == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < body.size(); i++) begin
            if ($urandom_range(0, 11) == 0)
                push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_char(body[i], 1'b1, !absent_end && i == body.size() - 1);
        end
        if (absent_end)
            push_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Sender: offers queued items, with a random gap after each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            in_taken = in_valid && !o_in_stall;
            if (in_taken) begin
                parse_char(in_code, in_present, in_last);
                chars_sent++;
                if (chars_sent % 100 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
            end
            if (in_taken || !in_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (char_feed.size() != 0 &&
                             !(char_feed[0].sync && parsed_results.size() != 0)) begin
                    next_char = char_feed.pop_front();
                    in_code    <= next_char.code;
                    in_present <= next_char.present;
                    in_last    <= next_char.last;
                    in_valid   <= 1'b1;
                    send_gap = (next_char.no_gap || send_quiet) ? 0 :
                               $urandom_range(0, MAX_GAP);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (parsed_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result expected none, got bool %0d err %0d count %0d",
                             $time, o_bool_value, o_error_code, o_consumed_count);
                end else begin
                    want = parsed_results.pop_front();
                    if (o_bool_value !== want.bool_value) begin
                        fail_count++;
                        $display("%0t: bool_value expected %0d, got %0d", $time,
                                 want.bool_value, o_bool_value);
                    end
                    if (o_error_code !== want.error_code) begin
                        fail_count++;
                        $display("%0t: error_code expected %0d, got %0d", $time,
                                 want.error_code, o_error_code);
                    end
                    if (o_consumed_count !== want.consumed_count) begin
                        fail_count++;
                        $display("%0t: consumed_count expected %0d, got %0d", $time,
                                 want.consumed_count, o_consumed_count);
                    end
                end
                results_seen++;
                if (results_seen % 16 == 0)
                    recv_quiet = ($urandom_range(0, 3) == 0);
                hold_left = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES :
                            recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[text_to_bool_parser] ERROR");
        $finish;
    end

    initial begin
        reset_parser();

        // Directed strings covering each form and the corner cases.
        push_char(8'h00, 1'b0, 1'b1);
        add_text("\t ");
        add_text("1");
        add_text("01x");
        add_text("11");
        add_text("Ye");
        add_text("oFf");
        add_text("On");
        add_text("ox");
        push_char(8'hFF, 1'b1, 1'b1);
        push_char(8'h00, 1'b1, 1'b1);
        push_char(CH_LO_N, 1'b1, 1'b0);
        push_char(8'hA5, 1'b0, 1'b0);
        push_char(CH_LO_O, 1'b1, 1'b1);
        add_text("true");
        push_char(8'h5A, 1'b0, 1'b1);

        // Random strings, with one pause of the sender half-way.
        while (stim_items < RANDOM_ITEMS / 2)
            add_random_string();
        push_char(CH_SPACE, 1'b1, 1'b0, 1'b0, 1'b1);
        while (stim_items < RANDOM_ITEMS)
            add_random_string();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_feed.size() != 0 || in_valid || parsed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (parsed_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("[text_to_bool_parser] OK");
        else
            $display("[text_to_bool_parser] ERROR");
        $finish;
    end

endmodule
